// ===== rtl/bit_field_packet_writer_top_macros.svh =====
// Assertion macros shared by the bit field packet writer RTL.
`ifndef BIT_FIELD_PACKET_WRITER_TOP_MACROS_SVH
`define BIT_FIELD_PACKET_WRITER_TOP_MACROS_SVH

// same-cycle implication, checked on clk, off during reset
`define BFPW_HOLDS(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on clk, off during reset
`define BFPW_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/bfpw_pkg.sv =====
// Types and constants of the bit field packet writer.
`default_nettype none

package bfpw_pkg;

	localparam int BYTE_W    = 8;
	localparam int VALUE_W   = 64;
	localparam int COUNT_W   = 7;
	localparam int INDEX_W   = 10;
	localparam int HEAD_W    = 14;
	localparam int LANE_W    = VALUE_W + BYTE_W;
	localparam logic [COUNT_W-1:0] MAX_FIELD_BITS = 7'd64;

	typedef enum logic {
		FN_APPEND = 1'b0,
		FN_FETCH  = 1'b1
	} func_t;

	typedef struct packed {
		func_t                func;
		logic [VALUE_W-1:0]   field_value;
		logic [COUNT_W-1:0]   bit_count;
		logic [INDEX_W-1:0]   byte_index;
	} in_word_t;

	typedef struct packed {
		logic                 accepted;
		logic [BYTE_W-1:0]    read_byte;
		logic [HEAD_W-1:0]    bit_head;
	} out_word_t;

	// sequencer -> byte lane
	typedef struct packed {
		logic load;
		logic step;
	} lane_ctl_t;

	// byte lane -> sequencer
	typedef struct packed {
		logic [BYTE_W-1:0] byte_out;
		logic              last;
		logic              tail_keep;
	} lane_sts_t;

endpackage

`default_nettype wire

// ===== rtl/bfpw_store.sv =====
// Byte store: one write port, one registered read port.
`default_nettype none

module bfpw_store import bfpw_pkg::*; #(
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [BYTE_W-1:0]        wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output      logic [BYTE_W-1:0]        rd_data
);

	logic [BYTE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/bfpw_lane.sv =====
// Byte lane: aligns the field once, then emits one masked byte per step.
`default_nettype none

module bfpw_lane import bfpw_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire lane_ctl_t          ctl,
	input  wire logic [VALUE_W-1:0] value,
	input  wire logic [COUNT_W-1:0] count,
	input  wire logic [2:0]         off,
	input  wire logic [BYTE_W-1:0]  tail,
	output      lane_sts_t          sts
);

	logic [LANE_W-1:0]  data_q;
	logic [COUNT_W-1:0] left_q;   // bits of the span still to write, tail bits included
	logic               full;
	logic [BYTE_W-1:0]  mask;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
		end else if (ctl.load) begin
			left_q <= COUNT_W'(off) + count;
		end else if (ctl.step) begin
			left_q <= full ? left_q - COUNT_W'(BYTE_W) : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			data_q <= (LANE_W'(value) << off) | LANE_W'(tail);
		end else if (ctl.step) begin
			data_q <= data_q >> BYTE_W;
		end
	end

	always_comb begin
		full          = left_q >= COUNT_W'(BYTE_W);
		mask          = full ? '1 : ~({BYTE_W{1'b1}} << left_q[2:0]);
		sts.byte_out  = data_q[BYTE_W-1:0] & mask;
		sts.last      = left_q <= COUNT_W'(BYTE_W);
		sts.tail_keep = !full;
	end

endmodule

`default_nettype wire

// ===== rtl/bit_field_packet_writer_top.sv =====
// Top level of the LSB-first bit field packet writer.
`default_nettype none
`include "bit_field_packet_writer_top_macros.svh"

// LSB-first bit field packer. A command word is taken when start is high and
// busy is low; exactly one result word follows, shown for one cycle with done
// high, and it must be taken then since the block cannot hold it. An append
// (func 0) ORs the low bit_count bits of field_value into the packet store at
// the current bit position if they fit within PACKET_BYTES*8 bits (counts
// above 64 are refused), advances the position and returns accepted 1;
// otherwise nothing changes and accepted is 0. A fetch (func 1) returns the
// stored byte at byte_index, accepted 0 and a zero byte beyond the store.
// bit_head always carries the low 14 bits of the position after the command.
// Sequence: a fetch goes from accept straight to the reply state; an append
// first passes through the write state, where the single byte lane writes
// one byte per cycle through the one store write port, for each store byte
// the field touches (0 to 9). The next command may start the cycle after done.
// No clearing pass is needed after reset: the byte at the current position
// is kept in a tail register, bytes ahead of it were never written and read
// as zero, so every store write is a plain write of a fully known byte.
module bit_field_packet_writer_top import bfpw_pkg::*; #(
	parameter int PACKET_BYTES = 1024
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	output      logic     busy,
	input  wire in_word_t cmd,
	output      logic     done,
	output      out_word_t result
);

	localparam int CAP_BITS = PACKET_BYTES * 8;
	localparam int AW       = $clog2(PACKET_BYTES);
	localparam int POS_W    = $clog2(CAP_BITS + 1);
	localparam int SW       = ((POS_W > COUNT_W) ? POS_W : COUNT_W) + 1;

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_WRITE = 3'b010,
		S_REPLY = 3'b100
	} state_t;

	state_t            state_q;
	logic [POS_W-1:0]  pos_q;     // bit write position
	logic [BYTE_W-1:0] tail_q;    // contents of the partly filled byte at pos_q
	logic [AW-1:0]     addr_q;    // store byte being written
	logic              acc_q;
	logic              fetch_q;
	logic              covered_q; // fetched byte lies below the position

	logic              accept;
	logic              is_fetch;
	logic              in_range;
	logic              covered;
	logic              fit;
	logic              span_zero;
	logic [SW-1:0]     sum;
	logic [2:0]        off;
	lane_ctl_t         lane_ctl;
	lane_sts_t         lane_sts;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic              rd_en;
	logic [BYTE_W-1:0] rd_data;

	always_comb begin
		accept    = start && (state_q == S_IDLE);
		is_fetch  = (cmd.func == FN_FETCH);
		in_range  = 32'(cmd.byte_index) < 32'(PACKET_BYTES);
		// a byte below ceil(pos/8) has been written at least once
		covered   = 32'({cmd.byte_index, 3'b000}) < 32'(pos_q);
		off       = pos_q[2:0];
		sum       = SW'(pos_q) + SW'(cmd.bit_count);
		fit       = (cmd.bit_count <= MAX_FIELD_BITS) && (sum <= SW'(CAP_BITS));
		// zero count: nothing to write, the tail byte stays as it is
		span_zero = (cmd.bit_count == '0);

		lane_ctl.load = accept && !is_fetch && fit && !span_zero;
		lane_ctl.step = (state_q == S_WRITE);

		wr_en   = (state_q == S_WRITE);
		wr_addr = addr_q;
		rd_en   = accept && is_fetch && in_range;
	end

	bfpw_lane u_lane (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (lane_ctl),
		.value  (cmd.field_value),
		.count  (cmd.bit_count),
		.off    (off),
		.tail   (tail_q),
		.sts    (lane_sts)
	);

	bfpw_store #(
		.DEPTH (PACKET_BYTES)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (lane_sts.byte_out),
		.rd_en   (rd_en),
		.rd_addr (AW'(cmd.byte_index)),
		.rd_data (rd_data)
	);

	// sequencer and position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pos_q   <= '0;
			tail_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (is_fetch || !fit) begin
							state_q <= S_REPLY;
						end else begin
							pos_q   <= POS_W'(sum);
							state_q <= span_zero ? S_REPLY : S_WRITE;
						end
					end
				end
				S_WRITE: begin
					if (lane_sts.last) begin
						// last byte holds the new partial byte, unless aligned
						tail_q  <= lane_sts.tail_keep ? lane_sts.byte_out : '0;
						state_q <= S_REPLY;
					end
				end
				S_REPLY: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// per-command result and write address
	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q    <= AW'(pos_q >> 3);
			acc_q     <= is_fetch ? in_range : fit;
			fetch_q   <= is_fetch;
			covered_q <= covered;
		end else if (state_q == S_WRITE) begin
			addr_q    <= addr_q + AW'(1);
		end
	end

	always_comb begin
		busy             = (state_q != S_IDLE);
		done             = (state_q == S_REPLY);
		result.accepted  = acc_q;
		result.read_byte = (fetch_q && acc_q && covered_q) ? rd_data : '0;
		result.bit_head  = HEAD_W'(pos_q);
	end

	`BFPW_HOLDS(a_pos_cap, 1'b1, 32'(pos_q) <= 32'(CAP_BITS), "position beyond capacity")
	`BFPW_NEXT(a_pos_hold, !(accept && !is_fetch), $stable(pos_q), "position moved without append")
	`BFPW_HOLDS(a_tail_clear, (state_q != S_WRITE) && (pos_q[2:0] == 3'd0), tail_q == '0, "tail not clear")
	`BFPW_HOLDS(a_wr_range, wr_en, 32'(wr_addr) < 32'(PACKET_BYTES), "store write out of range")
	`BFPW_NEXT(a_done_pulse, done, !done, "done longer than one cycle")

endmodule

`default_nettype wire
